>>> rtl/sha512_pkg.sv
// SHA-512 message digest: shared types, constants and round functions.
// No dependencies; used by every other file of the block.
package sha512_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned Rounds    = 80;
  localparam int unsigned DigWords  = 8;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_e;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       init;    // load working vars from hash state
    logic       step;    // run one round
    logic       fold;    // add working vars into hash state
    logic       reset_h; // restore initial hash values
    logic [6:0] rnd;     // round number
  } rnd_ctrl_t;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> rtl/sha512_if.sv
// Valid/ready stream channels of the SHA-512 block.
// Uses sha512_pkg for the word type.
interface sha512_in_if;
  logic               valid;
  logic               ready;
  sha512_pkg::word_t  message_word;
  logic [3:0]         byte_count;
  logic               last_word;
  modport source (output valid, message_word, byte_count, last_word, input ready);
  modport sink (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sha512_out_if;
  logic               valid;
  logic               ready;
  sha512_pkg::word_t  digest_word;
  logic [2:0]         digest_index;
  logic               digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

>>> rtl/sha512_round.sv
// SHA-512 round unit: working variables, hash state and one round per cycle.
// Uses sha512_pkg; takes the message schedule word from the schedule memory.
module sha512_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha512_pkg::rnd_ctrl_t ctrl_i,
  input  sha512_pkg::word_t    wt_i,
  input  logic [2:0]           hsel_i,
  output sha512_pkg::word_t    hword_o
);
  sha512_pkg::word_t h_q [8];
  sha512_pkg::word_t v_q [8];
  sha512_pkg::word_t t1, t2;

  // Compute one round.
  always_comb begin
    t1 = v_q[7] + (sha512_pkg::rotr(v_q[4], 14) ^ sha512_pkg::rotr(v_q[4], 18)
         ^ sha512_pkg::rotr(v_q[4], 41)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + sha512_pkg::round_k(ctrl_i.rnd) + wt_i;
    t2 = (sha512_pkg::rotr(v_q[0], 28) ^ sha512_pkg::rotr(v_q[0], 34)
         ^ sha512_pkg::rotr(v_q[0], 39))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Hold hash state; fold at block end, restore after a digest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::init_hash(3'(i));
    end else if (ctrl_i.reset_h) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::init_hash(3'(i));
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // Advance working variables.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (ctrl_i.step) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  assign hword_o = h_q[hsel_i];
endmodule

>>> rtl/sha512_sched.sv
// SHA-512 message buffer and schedule memory, 16 words, registered read.
// Uses sha512_pkg. Reads four taps a round through registered read ports.
module sha512_sched (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [3:0]        waddr_i,
  input  sha512_pkg::word_t wdata_i,
  input  logic [6:0]        rnd_i,   // round whose word is read next cycle
  output sha512_pkg::word_t wt_o
);
  // Four copies, each written alike, each with one read port.
  sha512_pkg::word_t m0 [16];
  sha512_pkg::word_t m2 [16];
  sha512_pkg::word_t m7 [16];
  sha512_pkg::word_t m15 [16];
  sha512_pkg::word_t r0_q, r2_q, r7_q, r15_q;
  logic              ext_q;
  logic [3:0]        wa_q;
  sha512_pkg::word_t s0, s1, wnew;
  logic              wr;
  logic [3:0]        wa;
  sha512_pkg::word_t wd;

  always_comb begin
    s1 = sha512_pkg::rotr(r2_q, 19) ^ sha512_pkg::rotr(r2_q, 61) ^ (r2_q >> 6);
    s0 = sha512_pkg::rotr(r15_q, 1) ^ sha512_pkg::rotr(r15_q, 8) ^ (r15_q >> 7);
    wnew = s1 + r7_q + s0 + r0_q;
    wt_o = ext_q ? wnew : r0_q;
    // Write back expanded words during rounds.
    wr = we_i || ext_q;
    wa = we_i ? waddr_i : wa_q;
    wd = we_i ? wdata_i : wnew;
  end

  // Read taps for the next round; forward the word written this cycle.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      m0[wa] <= wd; m2[wa] <= wd; m7[wa] <= wd; m15[wa] <= wd;
    end
    r0_q  <= (wr && wa == rnd_i[3:0]) ? wd : m0[rnd_i[3:0]];
    r2_q  <= (wr && wa == 4'(rnd_i[3:0] - 4'd2)) ? wd : m2[4'(rnd_i[3:0] - 4'd2)];
    r7_q  <= (wr && wa == 4'(rnd_i[3:0] - 4'd7)) ? wd : m7[4'(rnd_i[3:0] - 4'd7)];
    r15_q <= (wr && wa == 4'(rnd_i[3:0] - 4'd15)) ? wd : m15[4'(rnd_i[3:0] - 4'd15)];
    ext_q <= (rnd_i >= 7'd16) && (rnd_i < 7'd80);
    wa_q  <= rnd_i[3:0];
  end
endmodule

>>> rtl/sha512_message_digest.sv
// Top level of the SHA-512 message digest: byte packer, padding and sequencer.
// Uses sha512_pkg, sha512_if, sha512_sched and sha512_round.
//
// Message words are packed into a 16-word block memory; each full block runs
// 80 rounds at one round per cycle plus load and fold. In the idle state a
// word is accepted whenever it is valid; the word that fills a block holds off
// input for the compression. Padding writes the pad words and the length,
// with a compression whenever the block fills, and the eight digest words then
// leave one per transfer. Input is held off from the last word until the
// digest is taken.
module sha512_message_digest (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha512_in_if.sink            in_i,
  sha512_out_if.source         out_o
);
  sha512_pkg::state_e state_q, state_d;
  logic [63:0]  pw_q, pw_d;        // partial word
  logic [6:0]   fill_q, fill_d;    // bytes in block
  logic [63:0]  bits_q, bits_d;
  logic [6:0]   rnd_q, rnd_d;
  logic         last_q, last_d;    // padding in progress
  logic         mark_q, mark_d;    // 0x80 byte placed
  logic [2:0]   oidx_q, oidx_d;
  sha512_pkg::rnd_ctrl_t ctrl;
  logic         we;
  logic [3:0]   waddr;
  sha512_pkg::word_t wdata, wt, hword;
  logic [3:0]   cnt;
  logic [127:0] sh;
  logic [7:0]   nfill;
  logic [6:0]   rd_rnd;

  sha512_sched u_sched (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .rnd_i(rd_rnd), .wt_o(wt)
  );
  sha512_round u_round (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .wt_i(wt), .hsel_i(oidx_q), .hword_o(hword)
  );

  // Next state and datapath.
  always_comb begin
    state_d = state_q; pw_d = pw_q; fill_d = fill_q; bits_d = bits_q;
    rnd_d = rnd_q; last_d = last_q; mark_d = mark_q; oidx_d = oidx_q;
    we = 1'b0; waddr = fill_q[6:3]; wdata = '0;
    ctrl = '0; ctrl.rnd = rnd_q; rd_rnd = 7'd0;
    cnt = (in_i.byte_count > 4'd8) ? 4'd8 : in_i.byte_count;
    sh = '0; nfill = '0;
    unique case (state_q)
      sha512_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          // Append bytes; a word spans at most two memory words.
          sh = {64'(pw_q), in_i.message_word} >> (7'(8) * (7'd8 - 7'(cnt)));
          nfill = {1'b0, fill_q} + 8'(cnt);
          bits_d = bits_q + 64'({cnt, 3'b000});
          if (({1'b0, fill_q[2:0]} + cnt) > 4'd7) begin
            we = 1'b1; waddr = fill_q[6:3];
            // word completed: bytes up to boundary
            wdata = sh[63:0] >> {nfill[2:0], 3'b000}
                    | (sh[127:64] << (7'd64 - 7'({nfill[2:0], 3'b000})));
            if (nfill[2:0] == 3'd0) wdata = sh[63:0];
            pw_d = sh[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF << {nfill[2:0], 3'b000});
            if (nfill[2:0] == 3'd0) pw_d = '0;
          end else begin
            pw_d = sh[63:0];
          end
          fill_d = nfill[6:0];
          last_d = in_i.last_word;
          mark_d = 1'b0;
          if (nfill[7]) begin
            state_d = sha512_pkg::ST_LOAD;
          end else if (in_i.last_word) begin
            state_d = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        // Emit one padded word per cycle up to the length field, pausing for a compression when the block fills.
        if (fill_q == 7'd120 && mark_q) begin
          we = 1'b1; waddr = 4'd15; wdata = bits_q;
          fill_d = 7'd0; state_d = sha512_pkg::ST_LOAD; last_d = 1'b0;
          oidx_d = 3'd0;
        end else begin
          we = 1'b1; waddr = fill_q[6:3];
          if (!mark_q) begin
            wdata = (pw_q << 8 | 64'h80) << {3'd7 - fill_q[2:0], 3'b000};
          end else begin
            wdata = '0;
          end
          if (fill_q == 7'd112) wdata = mark_q ? 64'd0 : wdata;
          mark_d = 1'b1; pw_d = '0;
          fill_d = {fill_q[6:3] + 4'd1, 3'b000};
          if (fill_d == 7'd0) begin
            state_d = sha512_pkg::ST_LOAD; last_d = 1'b1;
          end else if (fill_q[6:3] == 4'd14 && !mark_q) begin
            // Marker leaves no room for the length: zero the last word first.
            fill_d = 7'd121;
          end
        end
      end
      sha512_pkg::ST_LOAD: begin
        ctrl.init = 1'b1; rnd_d = 7'd0; rd_rnd = 7'd0;
        state_d = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        ctrl.step = 1'b1;
        rd_rnd = rnd_q + 7'd1; rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(sha512_pkg::Rounds - 1)) state_d = sha512_pkg::ST_FOLD;
      end
      sha512_pkg::ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (last_q) state_d = sha512_pkg::ST_PAD;
        else if (mark_q) state_d = sha512_pkg::ST_OUT;
        else state_d = sha512_pkg::ST_IDLE;
      end
      sha512_pkg::ST_OUT: begin
        if (out_o.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ctrl.reset_h = 1'b1; state_d = sha512_pkg::ST_IDLE;
            bits_d = '0; mark_d = 1'b0; fill_d = '0; pw_d = '0;
          end
        end
      end
      default: state_d = sha512_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_i.ready = (state_q == sha512_pkg::ST_IDLE);
    out_o.valid = (state_q == sha512_pkg::ST_OUT);
    out_o.digest_word = hword;
    out_o.digest_index = oidx_q;
    out_o.digest_last = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::ST_IDLE; pw_q <= '0; fill_q <= '0; bits_q <= '0;
      rnd_q <= '0; last_q <= 1'b0; mark_q <= 1'b0; oidx_q <= '0;
    end else begin
      state_q <= state_d; pw_q <= pw_d; fill_q <= fill_d; bits_q <= bits_d;
      rnd_q <= rnd_d; last_q <= last_d; mark_q <= mark_d; oidx_q <= oidx_d;
    end
  end
endmodule

>>> tb/tb_sha512_message_digest.sv
// Testbench for sha512_message_digest: directed and random messages, digests
// checked against a built-in SHA-512 predictor. Uses sha512_pkg and sha512_if.
`timescale 1ns / 100ps

module tb_sha512_message_digest;

  typedef struct packed {
    sha512_pkg::word_t data;
    logic [3:0]        nbytes;
    logic              last;
  } msg_word_t;

  typedef struct packed {
    sha512_pkg::word_t word;
    logic [2:0]        index;
    logic              last;
  } digest_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  sha512_in_if  in_ch ();
  sha512_out_if out_ch ();

  sha512_message_digest dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Predictor state
  sha512_pkg::word_t blk_words [16];
  sha512_pkg::word_t acc_word;
  int unsigned       fill_bytes;
  sha512_pkg::word_t msg_bits;
  sha512_pkg::word_t chain [8];
  digest_t           digest_q [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;

  function automatic sha512_pkg::word_t ror(sha512_pkg::word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic hash_reset();
    acc_word = '0;
    fill_bytes = 0;
    msg_bits = '0;
    chain = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
              64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
              64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
  endtask

  task automatic compress();
    sha512_pkg::word_t w [16];
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t t1, t2, s0, s1;
    w = blk_words;
    v = chain;
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        s1 = ror(w[(t-2)&15], 19) ^ ror(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
        s0 = ror(w[(t-15)&15], 1) ^ ror(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
        w[t&15] = s1 + w[(t-7)&15] + s0 + w[t&15];
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::round_k(7'(t)) + w[t&15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic add_byte(logic [7:0] b);
    acc_word = {acc_word[55:0], b};
    fill_bytes++;
    if (fill_bytes % 8 == 0) begin
      blk_words[(fill_bytes - 1) / 8] = acc_word;
      acc_word = '0;
    end
    if (fill_bytes == 128) begin
      compress();
      fill_bytes = 0;
    end
  endtask

  // Absorb one word; on the last word pad, queue the digest and restart.
  task automatic predict_digest(msg_word_t m);
    int unsigned n;
    sha512_pkg::word_t len;
    n = (m.nbytes > 8) ? 8 : m.nbytes;
    for (int i = 0; i < n; i++) begin
      add_byte(m.data[63 - 8*i -: 8]);
      msg_bits += 8;
    end
    if (m.last) begin
      len = msg_bits;
      add_byte(8'h80);
      while (fill_bytes != 112) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) digest_q.push_back({chain[i], 3'(i), i == 7});
      hash_reset();
    end
  endtask

  // Directed table: extremes, empty message, zero and oversized counts.
  localparam int NumDirected = 14;
  msg_word_t directed [NumDirected] = '{
    '{64'h0, 4'd0, 1'b1},                      // empty message
    '{64'h6162630000000000, 4'd3, 1'b1},       // "abc"
    '{64'hffffffffffffffff, 4'd8, 1'b1},
    '{64'h0, 4'd8, 1'b1},
    '{64'hffffffffffffffff, 4'd15, 1'b0},      // count saturates to eight
    '{64'h0123456789abcdef, 4'd1, 1'b0},       // unused low bytes ignored
    '{64'hdeadbeefcafef00d, 4'd0, 1'b0},
    '{64'ha5a5a5a5a5a5a5a5, 4'd9, 1'b1},
    '{64'h5a5a5a5a5a5a5a5a, 4'd7, 1'b0},
    '{64'h8000000000000001, 4'd2, 1'b0},
    '{64'h7fffffffffffffff, 4'd4, 1'b0},
    '{64'hfedcba9876543210, 4'd5, 1'b0},
    '{64'h1111111111111111, 4'd6, 1'b0},
    '{64'h2222222222222222, 4'd8, 1'b1}
  };
  // Known digest word 0 of the empty message, typed in from the standard.
  localparam sha512_pkg::word_t EmptyDigest0 = 64'hcf83e1357eefb8bd;

  task automatic send(msg_word_t m);
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= m.data;
    in_ch.byte_count   <= m.nbytes;
    in_ch.last_word    <= m.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_digest(m);
  endtask

  task automatic idle_gap(int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_message(int unsigned nwords, bit ragged);
    msg_word_t m;
    for (int i = 0; i < nwords; i++) begin
      m.data   = {$urandom, $urandom};
      m.nbytes = ragged ? 4'($urandom_range(0, 15)) : 4'd8;
      m.last   = (i == nwords - 1);
      send(m);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  // Stimulus
  initial begin
    int unsigned sent;
    hash_reset();
    in_ch.valid <= 1'b0;
    in_ch.message_word <= '0;
    in_ch.byte_count <= '0;
    in_ch.last_word <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send(directed[i]);
      if (i == 0 && digest_q[0].word != EmptyDigest0) begin
        errors++;
        $display("predictor: empty digest %h", digest_q[0].word);
      end
    end

    // Hold until the digests drain, then stream random messages.
    idle_gap(1);
    while (digest_q.size() != 0) @(posedge clk_i);
    sent = NumDirected;
    while (sent < 130) begin
      int unsigned n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 6);
      if (sent + n > 130) n = 130 - sent;
      random_message(n, 1'($urandom_range(0, 1)));
      sent += n;
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
    end
    in_ch.valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver stalls on a rotating pattern with free-running stretches.
  logic [15:0] stall_pat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_pat <= 16'hb3c5;
      out_ch.ready <= 1'b0;
    end else begin
      stall_pat <= {stall_pat[14:0],
                    stall_pat[15] ^ stall_pat[13] ^ stall_pat[12] ^ stall_pat[10]};
      out_ch.ready <= (cycles[9:8] == 2'b01) ? 1'b1 : (stall_pat[1:0] != 2'b00);
    end
  end

  // Check each digest transfer against the oldest prediction.
  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h", out_ch.digest_word);
      end else begin
        want = digest_q.pop_front();
        if (want != {out_ch.digest_word, out_ch.digest_index, out_ch.digest_last}) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     want.word, want.index, want.last,
                     out_ch.digest_word, out_ch.digest_index, out_ch.digest_last);
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
